[rtl/cursor_linked_list_engine_defines.svh]
// Assertion macros for the cursor linked-list engine.
`ifndef CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define CLL_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("cll assertion failed");
`define CLL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("cll assertion failed");
`else
`define CLL_ASSERT_IMPL(label, clk, rst_n, a, b)
`define CLL_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/cll_pkg.sv]
// Package: operation codes, transaction types and defaults for the list engine.
`default_nettype none
package cll_pkg;
    localparam int CLL_CAPACITY = 2048;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_DELETE = 3'd1;
    localparam logic [2:0] FN_SEARCH = 3'd2;
    localparam logic [2:0] FN_INSERT = 3'd3;
    localparam logic [2:0] FN_REMOVE = 3'd4;
    localparam logic [2:0] FN_READ   = 3'd5;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key;
        logic [31:0]        payload;
        logic [11:0]        position;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] hit_key;
        logic [31:0]        hit_payload;
        logic [11:0]        entries;
        logic               is_empty;
        logic               is_full;
    } t_out_item;
endpackage
`default_nettype wire

[rtl/cursor_linked_list_engine.sv]
// Cursor linked-list engine: key/payload list kept in a node memory with a free list.
// Steps per transaction: each walked node takes a link read, then its use; append walks
//   to the tail, insert walks to the position (past the end as an append), remove and
//   read walk to the position, search/delete scan node by node, and delete scans on
//   after each removed match; a rejected transaction goes straight to the result.
// Throughput: one transaction at a time; a result waits in the output register.
// Reset: synchronous, active low; a fresh-slot counter replaces link clearing.
`default_nettype none
`include "cursor_linked_list_engine_defines.svh"
module cursor_linked_list_engine
    import cll_pkg::*;
#(
    parameter int CAPACITY = CLL_CAPACITY
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire t_in_item i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_data
);
    // Pointer width holds the null index (CAPACITY); address width indexes the memory.
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = (IW > 12) ? IW : 12;
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_WALK_W, S_GRAB, S_GRAB_W, S_LINK, S_LINK2,
        S_RNX, S_RNX_W, S_RDATA, S_RDATA_W, S_SCAN, S_SCAN_W,
        S_UNLINK, S_RELEASE, S_DONE
    } t_state;

    t_state r_state, r_after;

    // Node memories: links, and key/payload pairs.
    logic [IW-1:0] r_link_mem [CAPACITY];
    logic [63:0]   r_data_mem [CAPACITY];
    logic [IW-1:0] r_link_q;
    logic [63:0]   r_data_q;

    logic [IW-1:0] r_head, r_free, r_fresh, r_count;
    logic [IW-1:0] r_cur, r_prev, r_nx, r_node, r_steps;
    logic [2:0]    r_func;
    logic [31:0]   r_key, r_payload;
    logic          r_ok;
    logic [31:0]   r_hk, r_hp;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          link_we, data_we;
    logic [IW-1:0] link_wa, link_wd, link_ra;

    // Launch values for an accepted transaction.
    t_state        n_state, n_after;
    logic [IW-1:0] n_steps;
    logic          n_ok;

    // Input position, clamped to 1, compared at a common width with the count.
    logic [11:0]   pos1;
    logic [CW-1:0] pos_x, cnt_x;
    logic          full;

    assign pos1  = (i_in_data.position == 12'd0) ? 12'd1 : i_in_data.position;
    assign pos_x = CW'(pos1);
    assign cnt_x = CW'(r_count);
    assign full  = (r_count == NIL);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Decode the incoming transaction: walk length, where the walk ends, and early status.
    always_comb begin
        n_state = S_DONE;
        n_after = S_GRAB;
        n_steps = '0;
        n_ok    = 1'b0;
        case (i_in_data.func)
            FN_APPEND: begin
                if (!full) begin
                    n_steps = r_count;
                    n_ok    = 1'b1;
                    n_state = S_WALK;
                end
            end
            FN_INSERT: begin
                // Past the end: walk to the tail and append, report failure.
                if (!full) begin
                    n_steps = (pos_x > cnt_x) ? r_count : IW'(pos_x - 1'b1);
                    n_ok    = (pos_x <= cnt_x);
                    n_state = S_WALK;
                end
            end
            FN_DELETE, FN_SEARCH: begin
                n_state = S_SCAN;
            end
            FN_REMOVE, FN_READ: begin
                if (r_count != '0 && pos_x <= cnt_x) begin
                    n_steps = IW'(pos_x - 1'b1);
                    n_after = (i_in_data.func == FN_REMOVE) ? S_RNX : S_RDATA;
                    n_state = S_WALK;
                end
            end
            default: begin
            end
        endcase
    end

    // Memory port control: the walker reads at the cursor, a grab reads the free head.
    always_comb begin
        link_we = 1'b0;
        link_wa = r_node;
        link_wd = r_cur;
        data_we = 1'b0;
        link_ra = (r_state == S_GRAB) ? r_free : r_cur;
        case (r_state)
            S_GRAB: begin
                data_we = 1'b1;
            end
            S_LINK: begin
                link_we = 1'b1;
            end
            S_LINK2: begin
                link_we = (r_prev != NIL);
                link_wa = r_prev;
                link_wd = r_node;
            end
            S_UNLINK: begin
                link_we = (r_prev != NIL);
                link_wa = r_prev;
                link_wd = r_nx;
            end
            S_RELEASE: begin
                link_we = 1'b1;
                link_wa = r_cur;
                link_wd = r_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_wa[AW-1:0]] <= link_wd;
        end
        r_link_q <= r_link_mem[link_ra[AW-1:0]];
        if (data_we) begin
            r_data_mem[r_free[AW-1:0]] <= {r_key, r_payload};
        end
        r_data_q <= r_data_mem[r_cur[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_DONE;
            r_head      <= NIL;
            r_free      <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the held result once taken; a finishing transaction reloads it.
            if (i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func    <= i_in_data.func;
                        r_key     <= i_in_data.key;
                        r_payload <= i_in_data.payload;
                        r_prev    <= NIL;
                        r_cur     <= r_head;
                        r_ok      <= n_ok;
                        r_hk      <= '0;
                        r_hp      <= '0;
                        r_steps   <= n_steps;
                        r_after   <= n_after;
                        r_state   <= n_state;
                    end
                end
                S_WALK: begin
                    r_state <= (r_steps == '0) ? r_after : S_WALK_W;
                end
                S_WALK_W: begin
                    r_prev  <= r_cur;
                    r_cur   <= r_link_q;
                    r_steps <= r_steps - 1'b1;
                    r_state <= S_WALK;
                end
                S_GRAB: begin
                    // A slot at the fresh mark was never linked: its successor is the next slot.
                    r_node <= r_free;
                    if (r_free == r_fresh) begin
                        r_free  <= r_free + 1'b1;
                        r_fresh <= r_fresh + 1'b1;
                        r_state <= S_LINK;
                    end else begin
                        r_state <= S_GRAB_W;
                    end
                end
                S_GRAB_W: begin
                    r_free  <= r_link_q;
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    r_state <= S_LINK2;
                end
                S_LINK2: begin
                    if (r_prev == NIL) begin
                        r_head <= r_node;
                    end
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_RNX: begin
                    r_state <= S_RNX_W;
                end
                S_RNX_W: begin
                    r_nx    <= r_link_q;
                    r_state <= S_UNLINK;
                end
                S_RDATA: begin
                    r_state <= S_RDATA_W;
                end
                S_RDATA_W: begin
                    r_ok    <= 1'b1;
                    r_hk    <= r_data_q[63:32];
                    r_hp    <= r_data_q[31:0];
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    r_state <= (r_cur == NIL) ? S_DONE : S_SCAN_W;
                end
                S_SCAN_W: begin
                    r_nx <= r_link_q;
                    if (r_data_q[63:32] == r_key) begin
                        if (r_func == FN_SEARCH) begin
                            r_ok    <= 1'b1;
                            r_hk    <= r_data_q[63:32];
                            r_hp    <= r_data_q[31:0];
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_UNLINK;
                        end
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_link_q;
                        r_state <= S_SCAN;
                    end
                end
                S_UNLINK: begin
                    if (r_prev == NIL) begin
                        r_head <= r_nx;
                    end
                    r_state <= S_RELEASE;
                end
                S_RELEASE: begin
                    // Push the freed node on the front of the free list.
                    r_free  <= r_cur;
                    r_count <= r_count - 1'b1;
                    r_ok    <= 1'b1;
                    if (r_func == FN_DELETE) begin
                        r_cur   <= r_nx;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.ok          <= r_ok;
                        r_out.hit_key     <= r_hk;
                        r_out.hit_payload <= r_hp;
                        r_out.entries     <= 12'(r_count);
                        r_out.is_empty    <= (r_count == '0);
                        r_out.is_full     <= full;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CLL_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= NIL)
    `CLL_ASSERT_IMPL(a_empty_head, i_clk, i_rst_n, r_count == '0 && r_state == S_IDLE, r_head == NIL)
    `CLL_ASSERT_IMPL(a_fresh_bound, i_clk, i_rst_n, 1'b1, r_fresh <= NIL && r_count <= r_fresh)
    `CLL_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE && (!r_out_valid || i_out_ready), r_out_valid)
endmodule
`default_nettype wire
